// ===== rtl/core/dpp_pkg.sv =====
// Shared constants, fixed-point widths and helpers for the depth pixel to point block.
// Used by depth_pixel_to_point; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpp_pkg;

    // field widths
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int RAW_W      = 16;
    localparam int OUT_W      = 26;
    localparam int DEPTH_W    = 24;
    localparam int COLS_W     = 11;
    localparam int PHASE_W    = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam int IN_TDATA_W  = 40;    // 36 bits of fields padded to whole bytes
    localparam int OUT_TDATA_W = 80;    // 78 bits of fields padded to whole bytes

    localparam int MAX_DIM_DEFAULT = 1024;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_MIN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_SPAN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_COLS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP = 2'd3;

    // CORDIC, phase in 2^-24 turns, values Q30
    localparam int CORDIC_ITERS = 20;
    localparam int TRIG_W       = 33;
    localparam int ZACC_W       = 24;
    localparam int QUARTER_BITS = 22;
    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 33'sd652032874;

    localparam logic [QUARTER_BITS-1:0] ARC_TURNS [CORDIC_ITERS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669,
        22'd83416,   22'd41718,   22'd20860,  22'd10430,  22'd5215,
        22'd2608,    22'd1304,    22'd652,    22'd326,    22'd163,
        22'd81,      22'd41,      22'd20,     22'd10,     22'd5
    };

    // scaled values after a Q30 product
    localparam int VAL_W = 28;

    localparam logic signed [VAL_W:0] OUT_MAX = 29'sd33554431;
    localparam logic signed [VAL_W:0] OUT_MIN = -29'sd33554432;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [VAL_W:0] v);
        logic [OUT_W-1:0] r;
        if (v > OUT_MAX)
        begin
            r = OUT_MAX[OUT_W-1:0];
        end
        else if (v < OUT_MIN)
        begin
            r = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/depth_pixel_to_point.sv =====
// Depth pixel to 3D point converter: depth scaling, two pipelined CORDIC units,
// Q30 products and quarter placement. Depends on dpp_pkg.
//
// Usage:
//   Slave channel s_* takes one pixel per request; tdata = row, col, raw depth.
//   Master channel m_* gives one point per kept pixel; tdata = x, y, z.
//   Pixels with zero raw depth, a column at or beyond the image width, or a
//   row at or beyond MAX_DIM are dropped and give no request on m_*.
//   Configuration: cfg_we/cfg_addr/cfg_data write depth_min, depth_span,
//   image_cols and angle_step; write only while no pixel is in flight.
// Timing:
//   The pipe has 28 register stages: entry, three multipliers, CORDIC
//   set-up, 20 CORDIC iterations (one per stage, both angles in parallel),
//   quadrant fix, and two multiply/round pairs, the last of which is the
//   output register. Throughput is one pixel per cycle while m_tready
//   is high.
// Reset: all stage valid bits clear; registers return to depth_min = 0,
//   depth_span = 0, image_cols = 1024, angle_step = 16384.
// Stall: with m_tready low, stages fill up behind the output until the pipe
//   is full, then s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_to_point #(
    parameter int MAX_DIM = dpp_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // pixel in
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [dpp_pkg::IN_TDATA_W-1:0]      s_tdata,   // pixel_row, pixel_col, raw_depth, zero pad
    // point out
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [dpp_pkg::OUT_TDATA_W-1:0]     m_tdata,   // point_x, point_y, point_z, zero pad
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [dpp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [dpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import dpp_pkg::*;

    localparam int NST   = 28;
    localparam int ST_CS = 2;                    // CORDIC set-up stage
    localparam int ST_QF = ST_CS + CORDIC_ITERS + 1;
    localparam int ST_M1 = ST_QF + 1;
    localparam int ST_M2 = ST_M1 + 1;
    localparam int ST_M3 = ST_M2 + 1;
    localparam int ST_OUT = ST_M3 + 1;
    localparam int D_W   = DEPTH_W + 1;
    localparam int P1_W  = D_W + 1 + TRIG_W;
    localparam int P2_W  = VAL_W + TRIG_W;
    localparam int DPROD_W = RAW_W + DEPTH_W;
    localparam int QCALC_W = COLS_W + 2;

    localparam logic signed [P1_W-1:0] RND1 = P1_W'(1) <<< 29;
    localparam logic signed [P2_W-1:0] RND2 = P2_W'(1) <<< 29;

    // configuration registers
    logic [DEPTH_W-1:0] depth_min_reg;
    logic [DEPTH_W-1:0] depth_span_reg;
    logic [COLS_W-1:0]  image_cols_reg;
    logic [PHASE_W-1:0] angle_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_min_reg  <= '0;
            depth_span_reg <= '0;
            image_cols_reg <= COLS_W'(1024);
            angle_step_reg <= PHASE_W'(16384);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DEPTH_MIN:  depth_min_reg  <= cfg_data[DEPTH_W-1:0];
                REG_DEPTH_SPAN: depth_span_reg <= cfg_data[DEPTH_W-1:0];
                REG_IMAGE_COLS: image_cols_reg <= cfg_data[COLS_W-1:0];
                REG_ANGLE_STEP: angle_step_reg <= cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and per-stage advance
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    assign en[NST-1] = !v_reg[NST-1] || m_tready;
    for (genvar k = 0; k < NST-1; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NST-1];

    // entry: quarter selection and drop decision
    logic [ROW_W-1:0]   in_row;
    logic [COL_W-1:0]   in_col;
    logic [RAW_W-1:0]   in_raw;
    logic [COLS_W-1:0]  cols_eff;
    logic [QCALC_W-1:0] q1, q2, q3, cols_x, col_x, base;
    logic [1:0]         in_quarter;
    logic               in_keep;

    assign in_row = s_tdata[ROW_W-1:0];
    assign in_col = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_raw = s_tdata[ROW_W+COL_W+RAW_W-1:ROW_W+COL_W];

    always_comb
    begin
        cols_eff = (32'(image_cols_reg) > 32'(MAX_DIM)) ? COLS_W'(MAX_DIM) : image_cols_reg;
        cols_x   = QCALC_W'(cols_eff);
        col_x    = QCALC_W'(in_col);
        q1       = cols_x >> 2;
        q2       = cols_x >> 1;
        q3       = ((cols_x << 1) + cols_x) >> 2;
        if (col_x < q1)
        begin
            in_quarter = 2'd0;
            base       = '0;
        end
        else if (col_x < q2)
        begin
            in_quarter = 2'd1;
            base       = q1;
        end
        else if (col_x < q3)
        begin
            in_quarter = 2'd2;
            base       = q2;
        end
        else
        begin
            in_quarter = 2'd3;
            base       = q3;
        end
        in_keep = (in_raw != '0) && (col_x < cols_x) && (32'(in_row) < 32'(MAX_DIM));
    end

    logic [ROW_W-1:0] row0_reg;
    logic [COL_W-1:0] off0_reg;
    logic [RAW_W-1:0] raw0_reg;
    logic [1:0]       qtr0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            v_reg[0] <= s_tvalid && in_keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            row0_reg <= in_row;
            off0_reg <= COL_W'(col_x - base);
            raw0_reg <= in_raw;
            qtr0_reg <= in_quarter;
        end
    end

    for (genvar k = 1; k < NST; k++)
    begin : g_valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: phases and scaled raw depth
    logic [PHASE_W-1:0] th1_reg, ph1_reg;
    logic [DPROD_W-1:0] dprod1_reg;
    logic [1:0]         qtr1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            th1_reg    <= PHASE_W'(PHASE_W'(row0_reg) * angle_step_reg);
            ph1_reg    <= PHASE_W'(PHASE_W'(off0_reg) * angle_step_reg);
            dprod1_reg <= DPROD_W'(raw0_reg) * DPROD_W'(depth_span_reg);
            qtr1_reg   <= qtr0_reg;
        end
    end

    // CORDIC pipelines; index j holds the pair after j iterations
    logic signed [TRIG_W-1:0] tx_reg [0:CORDIC_ITERS];
    logic signed [TRIG_W-1:0] ty_reg [0:CORDIC_ITERS];
    logic signed [ZACC_W-1:0] tz_reg [0:CORDIC_ITERS];
    logic signed [TRIG_W-1:0] px_reg [0:CORDIC_ITERS];
    logic signed [TRIG_W-1:0] py_reg [0:CORDIC_ITERS];
    logic signed [ZACC_W-1:0] pz_reg [0:CORDIC_ITERS];
    logic [1:0]               tq_reg [0:CORDIC_ITERS];
    logic [1:0]               pq_reg [0:CORDIC_ITERS];
    logic [1:0]               qt_reg [0:CORDIC_ITERS];
    logic [D_W-1:0]           dp_reg [0:CORDIC_ITERS];

    always_ff @(posedge clk)
    begin
        if (en[ST_CS])
        begin
            tx_reg[0] <= CORDIC_X0;
            ty_reg[0] <= '0;
            tz_reg[0] <= ZACC_W'(th1_reg[QUARTER_BITS-1:0]);
            tq_reg[0] <= th1_reg[PHASE_W-1:QUARTER_BITS];
            px_reg[0] <= CORDIC_X0;
            py_reg[0] <= '0;
            pz_reg[0] <= ZACC_W'(ph1_reg[QUARTER_BITS-1:0]);
            pq_reg[0] <= ph1_reg[PHASE_W-1:QUARTER_BITS];
            qt_reg[0] <= qtr1_reg;
            dp_reg[0] <= D_W'(depth_min_reg) + D_W'(dprod1_reg[DPROD_W-1:RAW_W]);
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_cordic
        localparam logic signed [ZACC_W-1:0] ARC = ZACC_W'(ARC_TURNS[i]);

        always_ff @(posedge clk)
        begin
            if (en[ST_CS+1+i])
            begin
                if (!tz_reg[i][ZACC_W-1])
                begin
                    tx_reg[i+1] <= tx_reg[i] - (ty_reg[i] >>> i);
                    ty_reg[i+1] <= ty_reg[i] + (tx_reg[i] >>> i);
                    tz_reg[i+1] <= tz_reg[i] - ARC;
                end
                else
                begin
                    tx_reg[i+1] <= tx_reg[i] + (ty_reg[i] >>> i);
                    ty_reg[i+1] <= ty_reg[i] - (tx_reg[i] >>> i);
                    tz_reg[i+1] <= tz_reg[i] + ARC;
                end
                if (!pz_reg[i][ZACC_W-1])
                begin
                    px_reg[i+1] <= px_reg[i] - (py_reg[i] >>> i);
                    py_reg[i+1] <= py_reg[i] + (px_reg[i] >>> i);
                    pz_reg[i+1] <= pz_reg[i] - ARC;
                end
                else
                begin
                    px_reg[i+1] <= px_reg[i] + (py_reg[i] >>> i);
                    py_reg[i+1] <= py_reg[i] - (px_reg[i] >>> i);
                    pz_reg[i+1] <= pz_reg[i] + ARC;
                end
                tq_reg[i+1] <= tq_reg[i];
                pq_reg[i+1] <= pq_reg[i];
                qt_reg[i+1] <= qt_reg[i];
                dp_reg[i+1] <= dp_reg[i];
            end
        end
    end

    // quadrant fix: whole quarter turns from the top phase bits
    logic signed [TRIG_W-1:0] ct_reg, st_reg, cp_reg, sp_reg;
    logic [1:0]               qtr_qf_reg;
    logic [D_W-1:0]           d_qf_reg;
    logic signed [TRIG_W-1:0] tx_f, ty_f, px_f, py_f;

    assign tx_f = tx_reg[CORDIC_ITERS];
    assign ty_f = ty_reg[CORDIC_ITERS];
    assign px_f = px_reg[CORDIC_ITERS];
    assign py_f = py_reg[CORDIC_ITERS];

    always_ff @(posedge clk)
    begin
        if (en[ST_QF])
        begin
            case (tq_reg[CORDIC_ITERS])
                2'd0:
                begin
                    ct_reg <= tx_f;
                    st_reg <= ty_f;
                end
                2'd1:
                begin
                    ct_reg <= -ty_f;
                    st_reg <= tx_f;
                end
                2'd2:
                begin
                    ct_reg <= -tx_f;
                    st_reg <= -ty_f;
                end
                default:
                begin
                    ct_reg <= ty_f;
                    st_reg <= -tx_f;
                end
            endcase
            case (pq_reg[CORDIC_ITERS])
                2'd0:
                begin
                    cp_reg <= px_f;
                    sp_reg <= py_f;
                end
                2'd1:
                begin
                    cp_reg <= -py_f;
                    sp_reg <= px_f;
                end
                2'd2:
                begin
                    cp_reg <= -px_f;
                    sp_reg <= -py_f;
                end
                default:
                begin
                    cp_reg <= py_f;
                    sp_reg <= -px_f;
                end
            endcase
            qtr_qf_reg <= qt_reg[CORDIC_ITERS];
            d_qf_reg   <= dp_reg[CORDIC_ITERS];
        end
    end

    // M1: d * cos(theta), d * sin(theta)
    logic signed [P1_W-1:0]   yprod_reg, sprod_reg;
    logic signed [TRIG_W-1:0] cp_m1_reg, sp_m1_reg;
    logic [1:0]               qtr_m1_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_M1])
        begin
            yprod_reg  <= P1_W'($signed({1'b0, d_qf_reg})) * P1_W'(ct_reg);
            sprod_reg  <= P1_W'($signed({1'b0, d_qf_reg})) * P1_W'(st_reg);
            cp_m1_reg  <= cp_reg;
            sp_m1_reg  <= sp_reg;
            qtr_m1_reg <= qtr_qf_reg;
        end
    end

    // M2: round half up to 8 fraction bits
    logic signed [P1_W-1:0]   ysum, ssum;
    logic signed [VAL_W-1:0]  y_m2_reg, s_m2_reg;
    logic signed [TRIG_W-1:0] cp_m2_reg, sp_m2_reg;
    logic [1:0]               qtr_m2_reg;

    assign ysum = yprod_reg + RND1;
    assign ssum = sprod_reg + RND1;

    always_ff @(posedge clk)
    begin
        if (en[ST_M2])
        begin
            y_m2_reg   <= ysum[VAL_W+29:30];
            s_m2_reg   <= ssum[VAL_W+29:30];
            cp_m2_reg  <= cp_m1_reg;
            sp_m2_reg  <= sp_m1_reg;
            qtr_m2_reg <= qtr_m1_reg;
        end
    end

    // M3: s * sin(phi), s * cos(phi)
    logic signed [P2_W-1:0]  psprod_reg, pcprod_reg;
    logic signed [VAL_W-1:0] y_m3_reg;
    logic [1:0]              qtr_m3_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_M3])
        begin
            psprod_reg <= P2_W'(s_m2_reg) * P2_W'(sp_m2_reg);
            pcprod_reg <= P2_W'(s_m2_reg) * P2_W'(cp_m2_reg);
            y_m3_reg   <= y_m2_reg;
            qtr_m3_reg <= qtr_m2_reg;
        end
    end

    // output: round, place by column quarter, saturate
    logic signed [P2_W-1:0] pssum, pcsum;
    logic signed [VAL_W:0]  ps_v, pc_v, x_v, z_v;
    logic [OUT_W-1:0]       x_out_reg, y_out_reg, z_out_reg;

    always_comb
    begin
        pssum = psprod_reg + RND2;
        pcsum = pcprod_reg + RND2;
        ps_v  = (VAL_W+1)'($signed(pssum[VAL_W+29:30]));
        pc_v  = (VAL_W+1)'($signed(pcsum[VAL_W+29:30]));
        case (qtr_m3_reg)
            2'd0:
            begin
                x_v = -ps_v;
                z_v = -pc_v;
            end
            2'd1:
            begin
                x_v = -pc_v;
                z_v = ps_v;
            end
            2'd2:
            begin
                x_v = ps_v;
                z_v = pc_v;
            end
            default:
            begin
                x_v = pc_v;
                z_v = -ps_v;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            x_out_reg <= sat_out(x_v);
            y_out_reg <= sat_out((VAL_W+1)'(y_m3_reg));
            z_out_reg <= sat_out(z_v);
        end
    end

    assign m_tdata = {(OUT_TDATA_W-3*OUT_W)'(0), z_out_reg, y_out_reg, x_out_reg};

endmodule

`default_nettype wire
